>>> rtl/core/dps_pkg.sv
package dps_pkg;

	localparam int NUM_STACKS  = 10;
	localparam int STACK_DEPTH = 16;

	localparam int SIDX_W  = $clog2(NUM_STACKS);
	localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
	localparam int STORE_N = NUM_STACKS * STACK_DEPTH;
	localparam int ADDR_W  = $clog2(STORE_N);

	localparam int VAL_W  = 32;
	localparam int KIND_W = 2;
	localparam int SNUM_W = 4;
	localparam int STAT_W = 2;
	localparam int CFG_W  = 5;

	localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_POP_AT = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	localparam logic [VAL_W-1:0] NONE_VALUE = 32'hFFFF_FFFF;
	localparam logic [CFG_W-1:0] CFG_RESET  = 5'd16;

	typedef struct packed {
		logic [KIND_W-1:0]       kind;
		logic signed [VAL_W-1:0] push_value;
		logic [SNUM_W-1:0]       stack_number;
	} req_t;

	typedef struct packed {
		logic                    vld;
		logic signed [VAL_W-1:0] value;
		logic [STAT_W-1:0]       status;
	} fin_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [VAL_W-1:0]  wdata;
	} ram_cmd_t;

endpackage

>>> rtl/core/dps_req_if.sv
interface dps_req_if;
	logic                                      valid;
	logic                                      ready;
	logic [dps_pkg::KIND_W-1:0]                kind;
	logic signed [dps_pkg::VAL_W-1:0]          push_value;
	logic [dps_pkg::SNUM_W-1:0]                stack_number;

	modport source (output valid, kind, push_value, stack_number, input ready);
	modport sink (input valid, kind, push_value, stack_number, output ready);
endinterface

>>> rtl/core/dps_rsp_if.sv
interface dps_rsp_if;
	logic                                      valid;
	logic                                      ready;
	logic signed [dps_pkg::VAL_W-1:0]          popped_value;
	logic [dps_pkg::STAT_W-1:0]                status;

	modport source (output valid, popped_value, status, input ready);
	modport sink (input valid, popped_value, status, output ready);
endinterface

>>> rtl/core/dps_ram.sv
module dps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 160
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

>>> rtl/core/dps_seq.sv
module dps_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  dps_pkg::req_t               req,
	output logic                        req_ready,
	input  logic [dps_pkg::CFG_W-1:0]   cap_cfg,
	input  logic                        out_free,
	output dps_pkg::fin_t               fin,
	output dps_pkg::ram_cmd_t           ram_cmd,
	input  logic [dps_pkg::VAL_W-1:0]   ram_rdata
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_READ,
		S_FINISH
	} state_t;

	state_t                               state_q;
	logic [dps_pkg::KIND_W-1:0]           kind_q;
	logic [dps_pkg::VAL_W-1:0]            val_q;
	logic [dps_pkg::SIDX_W-1:0]           idx_q;
	logic [dps_pkg::VAL_W-1:0]            res_val_q;
	logic [dps_pkg::STAT_W-1:0]           res_st_q;
	logic [dps_pkg::CNT_W-1:0]            cnt_q [dps_pkg::NUM_STACKS];

	logic [dps_pkg::CNT_W-1:0]            cap_eff;
	logic [dps_pkg::CNT_W-1:0]            cnt_rd;
	logic [dps_pkg::CNT_W-1:0]            slot;
	logic [dps_pkg::ADDR_W-1:0]           base;
	logic                                 is_push;
	logic                                 hit;
	logic                                 last;
	logic                                 sn_ok;

	// one count compared per cycle
	always_comb begin
		if (32'(cap_cfg) > 32'(dps_pkg::STACK_DEPTH)) begin
			cap_eff = dps_pkg::CNT_W'(dps_pkg::STACK_DEPTH);
		end else begin
			cap_eff = dps_pkg::CNT_W'(cap_cfg);
		end
		cnt_rd  = cnt_q[idx_q];
		is_push = (kind_q == dps_pkg::KIND_PUSH);
		hit     = is_push ? (cnt_rd < cap_eff) : (cnt_rd != '0);
		last    = (kind_q == dps_pkg::KIND_POP_AT)
			|| (is_push && idx_q == dps_pkg::SIDX_W'(dps_pkg::NUM_STACKS - 1))
			|| (!is_push && idx_q == '0);
		slot    = is_push ? cnt_rd : dps_pkg::CNT_W'(cnt_rd - 1'b1);
		base    = dps_pkg::ADDR_W'(idx_q) * dps_pkg::ADDR_W'(dps_pkg::STACK_DEPTH);
		sn_ok   = 32'(req.stack_number) < 32'(dps_pkg::NUM_STACKS);

		ram_cmd.we    = (state_q == S_SCAN) && hit && is_push;
		ram_cmd.addr  = dps_pkg::ADDR_W'(base + dps_pkg::ADDR_W'(slot));
		ram_cmd.wdata = val_q;

		req_ready  = (state_q == S_IDLE);
		fin.vld    = (state_q == S_FINISH);
		fin.value  = res_val_q;
		fin.status = res_st_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			kind_q    <= dps_pkg::KIND_PUSH;
			val_q     <= '0;
			idx_q     <= '0;
			res_val_q <= dps_pkg::NONE_VALUE;
			res_st_q  <= dps_pkg::ST_OK;
			for (int i = 0; i < dps_pkg::NUM_STACKS; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						kind_q    <= req.kind;
						val_q     <= req.push_value;
						res_val_q <= dps_pkg::NONE_VALUE;
						case (req.kind)
							dps_pkg::KIND_PUSH: begin
								idx_q   <= '0;
								state_q <= S_SCAN;
							end
							dps_pkg::KIND_POP: begin
								idx_q   <= dps_pkg::SIDX_W'(dps_pkg::NUM_STACKS - 1);
								state_q <= S_SCAN;
							end
							dps_pkg::KIND_POP_AT: begin
								idx_q <= dps_pkg::SIDX_W'(req.stack_number);
								if (sn_ok) begin
									state_q <= S_SCAN;
								end else begin
									res_st_q <= dps_pkg::ST_EMPTY;
									state_q  <= S_FINISH;
								end
							end
							default: begin
								res_st_q <= dps_pkg::ST_OK;
								state_q  <= S_FINISH;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (hit) begin
						if (is_push) begin
							cnt_q[idx_q] <= dps_pkg::CNT_W'(cnt_rd + 1'b1);
							res_st_q     <= dps_pkg::ST_OK;
							state_q      <= S_FINISH;
						end else begin
							cnt_q[idx_q] <= slot;
							state_q      <= S_READ;
						end
					end else if (last) begin
						res_st_q <= is_push ? dps_pkg::ST_FULL : dps_pkg::ST_EMPTY;
						state_q  <= S_FINISH;
					end else if (is_push) begin
						idx_q <= dps_pkg::SIDX_W'(idx_q + 1'b1);
					end else begin
						idx_q <= dps_pkg::SIDX_W'(idx_q - 1'b1);
					end
				end
				S_READ: begin
					res_val_q <= ram_rdata;
					res_st_q  <= dps_pkg::ST_OK;
					state_q   <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/dinner_plate_stack_set.sv
// Row of stacks sharing one capacity register (cfg_we/cfg_wdata, values above the
// build depth act as the build depth). A push lands on the leftmost stack that is not
// full, a pop takes the top of the rightmost non-empty stack, a pop-at takes the top
// of the named stack; every request gives exactly one result. One request is handled
// at a time: a single count comparator steps one stack per cycle, and a push, or a pop
// that finds nothing, then goes to the finish state, while a pop that takes a value
// passes through a read state first for the registered read of the value store.
// Kind 3 and an out-of-range pop-at go from idle straight to the finish state. The
// result sits in an output register, so a new request is taken while it waits; a
// finished request holds as long as the previous result is still waiting there.
module dinner_plate_stack_set (
	input  logic                        clk,
	input  logic                        arst_n,
	dps_req_if.sink                     req,
	dps_rsp_if.source                   rsp,
	input  logic                        cfg_we,
	input  logic [dps_pkg::CFG_W-1:0]   cfg_wdata
);

	logic [dps_pkg::CFG_W-1:0]         cap_q;
	logic                              rsp_valid_q;
	logic [dps_pkg::VAL_W-1:0]         popped_value_q;
	logic [dps_pkg::STAT_W-1:0]        status_q;
	logic                              out_free;
	dps_pkg::req_t                     req_data;
	dps_pkg::fin_t                     fin;
	dps_pkg::ram_cmd_t                 ram_cmd;
	logic [dps_pkg::VAL_W-1:0]         ram_rdata;

	assign req_data.kind         = req.kind;
	assign req_data.push_value   = req.push_value;
	assign req_data.stack_number = req.stack_number;

	assign out_free         = !rsp_valid_q || rsp.ready;
	assign rsp.valid        = rsp_valid_q;
	assign rsp.popped_value = popped_value_q;
	assign rsp.status       = status_q;

	dps_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req       (req_data),
		.req_ready (req.ready),
		.cap_cfg   (cap_q),
		.out_free  (out_free),
		.fin       (fin),
		.ram_cmd   (ram_cmd),
		.ram_rdata (ram_rdata)
	);

	dps_ram #(
		.WIDTH (dps_pkg::VAL_W),
		.DEPTH (dps_pkg::STORE_N)
	) u_store (
		.clk   (clk),
		.we    (ram_cmd.we),
		.addr  (ram_cmd.addr),
		.wdata (ram_cmd.wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= dps_pkg::CFG_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (fin.vld && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fin.vld && out_free) begin
			popped_value_q <= fin.value;
			status_q       <= fin.status;
		end
	end

endmodule

>>> tb/sv/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dps_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 2 * (NUM_STACKS + 3) + 4;
	localparam int HOLD_CYCLES   = 300;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [STAT_W-1:0]       status;
	} plate_result_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_W-1:0]    cfg_wdata;

	dps_req_if req_ch ();
	dps_rsp_if rsp_ch ();

	dinner_plate_stack_set i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	req_t          pending_ops[$];
	plate_result_t results_due[$];

	logic [CFG_W-1:0] shelf_capacity = CFG_RESET;
	int               plate_counts[NUM_STACKS];
	logic [VAL_W-1:0] plate_mem[NUM_STACKS][STACK_DEPTH];

	int fail_count   = 0;
	bit req_fire     = 1'b0;
	bit steady       = 1'b0;
	bit hold_trigger = 1'b0;
	int hold_left    = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic plate_result_t predict_plate_op(input req_t op);
		plate_result_t res;
		int            cap;
		int            target;
		bit            placed;
		res.value  = NONE_VALUE;
		res.status = ST_OK;
		cap        = (int'(shelf_capacity) > STACK_DEPTH) ? STACK_DEPTH
			: int'(shelf_capacity);
		target     = -1;
		placed     = 1'b0;
		case (op.kind)
			KIND_PUSH: begin
				res.status = ST_FULL;
				for (int s = 0; s < NUM_STACKS; s++) begin
					if (!placed && plate_counts[s] < cap) begin
						plate_mem[s][plate_counts[s]] = op.push_value;
						plate_counts[s]++;
						placed     = 1'b1;
						res.status = ST_OK;
					end
				end
			end
			KIND_POP: begin
				for (int s = NUM_STACKS - 1; s >= 0; s--) begin
					if (target < 0 && plate_counts[s] != 0)
						target = s;
				end
			end
			KIND_POP_AT: begin
				if (int'(op.stack_number) < NUM_STACKS && plate_counts[op.stack_number] != 0)
					target = int'(op.stack_number);
			end
			default: ;
		endcase
		if (op.kind == KIND_POP || op.kind == KIND_POP_AT) begin
			if (target < 0) begin
				res.status = ST_EMPTY;
			end else begin
				plate_counts[target]--;
				res.value = plate_mem[target][plate_counts[target]];
			end
		end
		return res;
	endfunction

	task automatic log_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t ns: %s", $realtime, msg);
	endtask

	task automatic add_op(input logic [KIND_W-1:0] k, input logic [VAL_W-1:0] v,
			input logic [SNUM_W-1:0] sn);
		req_t op;
		op.kind         = k;
		op.push_value   = v;
		op.stack_number = sn;
		pending_ops.push_back(op);
	endtask

	task automatic random_ops(input int count, input int push_pct);
		int                roll;
		int                pop_edge;
		logic [SNUM_W-1:0] sn;
		pop_edge = push_pct + (97 - push_pct) / 2;
		for (int n = 0; n < count; n++) begin
			roll = int'($urandom_range(99));
			if ($urandom_range(9) == 0)
				sn = SNUM_W'($urandom_range(15, NUM_STACKS));
			else
				sn = SNUM_W'($urandom_range(NUM_STACKS - 1));
			if (roll < push_pct)
				add_op(KIND_PUSH, $urandom(), sn);
			else if (roll < pop_edge)
				add_op(KIND_POP, $urandom(), sn);
			else if (roll < 97)
				add_op(KIND_POP_AT, $urandom(), sn);
			else
				add_op(KIND_UNUSED, $urandom(), sn);
		end
	endtask

	task automatic drain_all();
		while (pending_ops.size() != 0 || req_ch.valid || results_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_capacity(input logic [CFG_W-1:0] cap);
		drain_all();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = cap;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// next request onto the bus once the current one is taken
	always @(negedge clk) begin : drive_requests
		req_t nxt;
		bit   offer;
		if (arst_n && (!req_ch.valid || req_fire)) begin
			offer = pending_ops.size() != 0 && (steady || $urandom_range(99) >= 16);
			if (offer) begin
				nxt = pending_ops.pop_front();
				req_ch.valid        <= 1'b1;
				req_ch.kind         <= nxt.kind;
				req_ch.push_value   <= nxt.push_value;
				req_ch.stack_number <= nxt.stack_number;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : drive_ready
		if (arst_n) begin
			if (hold_trigger) begin
				hold_trigger = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= steady || ($urandom_range(99) >= 16);
			end
		end
	end

	always @(posedge clk) begin : watch_results
		plate_result_t due;
		plate_result_t got;
		req_t          op;
		req_fire = arst_n && req_ch.valid && req_ch.ready;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.value  = rsp_ch.popped_value;
			got.status = rsp_ch.status;
			if (results_due.size() == 0) begin
				log_failure($sformatf("unexpected result: value %0d status %0d",
					got.value, got.status));
			end else begin
				due = results_due.pop_front();
				if (got.value !== due.value || got.status !== due.status)
					log_failure($sformatf(
						"mismatch: expected value %0d status %0d, got value %0d status %0d",
						due.value, due.status, got.value, got.status));
			end
		end
		if (arst_n && cfg_we)
			shelf_capacity = cfg_wdata;
		if (req_fire) begin
			op.kind         = req_ch.kind;
			op.push_value   = req_ch.push_value;
			op.stack_number = req_ch.stack_number;
			results_due.push_back(predict_plate_op(op));
		end
	end

	initial begin
		#2_000_000;
		$display("dinner_plate_stack_set test failed");
		$finish;
	end

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = CFG_RESET;
		req_ch.valid        = 1'b0;
		req_ch.kind         = KIND_PUSH;
		req_ch.push_value   = '0;
		req_ch.stack_number = '0;
		rsp_ch.ready        = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty set, out-of-range stack, unused kind, value extremes
		add_op(KIND_POP, 32'h0, 4'd0);
		add_op(KIND_POP_AT, 32'h0, 4'd0);
		add_op(KIND_POP_AT, 32'hFFFF_FFFF, 4'd15);
		add_op(KIND_UNUSED, 32'h1234_5678, 4'd3);
		add_op(KIND_PUSH, 32'h7FFF_FFFF, 4'd0);
		add_op(KIND_PUSH, 32'h8000_0000, 4'd15);
		add_op(KIND_PUSH, 32'h0000_0000, 4'd0);
		add_op(KIND_PUSH, 32'hFFFF_FFFF, 4'd0);
		add_op(KIND_POP_AT, 32'h0, 4'd0);
		add_op(KIND_POP, 32'h0, 4'd0);
		add_op(KIND_POP_AT, 32'h0, 4'd10);

		// capacity below stack 0 fill, then every stack full
		set_capacity(5'd1);
		for (int n = 0; n < NUM_STACKS; n++)
			add_op(KIND_PUSH, 32'h100 + n, 4'd0);
		add_op(KIND_POP_AT, 32'h0, 4'd9);
		add_op(KIND_POP, 32'h0, 4'd0);
		add_op(KIND_POP_AT, 32'h0, 4'd0);

		set_capacity(5'd0);
		add_op(KIND_PUSH, 32'h5A5A_A5A5, 4'd0);
		add_op(KIND_POP, 32'h0, 4'd0);

		set_capacity(5'd3);
		random_ops(55, 70);
		random_ops(35, 25);
		drain_all();
		hold_trigger = 1'b1;
		random_ops(40, 50);

		set_capacity(5'd31);
		steady = 1'b1;
		random_ops(60, 60);
		drain_all();
		steady = 1'b0;

		set_capacity(5'd1);
		random_ops(45, 55);

		set_capacity(5'd16);
		random_ops(30, 90);
		set_capacity(5'd4);
		hold_trigger = 1'b1;
		random_ops(45, 50);

		set_capacity(5'd0);
		random_ops(20, 50);

		set_capacity(5'd16);
		random_ops(50, 50);

		drain_all();
		if (results_due.size() != 0)
			log_failure($sformatf("%0d results never arrived", results_due.size()));
		if (fail_count == 0)
			$display("dinner_plate_stack_set test passed");
		else
			$display("dinner_plate_stack_set test failed");
		$finish;
	end
endmodule
